### rtl/crtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crtn_pkg;

	localparam int RadicandW = 64;
	localparam int RootW     = 22;
	localparam int EstW      = 23;
	localparam int DenW      = 46;
	localparam int QuoW      = 32;
	localparam int SmallW    = 3;

	localparam logic [7:0] SEED_TABLE [64] = '{
		8'd0,   8'd54,  8'd54,  8'd54,  8'd118, 8'd118, 8'd118, 8'd118,
		8'd123, 8'd129, 8'd134, 8'd138, 8'd143, 8'd147, 8'd151, 8'd156,
		8'd157, 8'd161, 8'd164, 8'd168, 8'd170, 8'd173, 8'd176, 8'd179,
		8'd181, 8'd185, 8'd187, 8'd190, 8'd192, 8'd194, 8'd197, 8'd199,
		8'd200, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
		8'd217, 8'd219, 8'd221, 8'd222, 8'd224, 8'd225, 8'd227, 8'd229,
		8'd231, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242,
		8'd244, 8'd245, 8'd246, 8'd248, 8'd250, 8'd251, 8'd252, 8'd254
	};

	localparam logic [8:0] SMALL_ROUND = 9'd35;
	localparam logic [8:0] SEED_BIAS   = 9'd10;
	localparam logic [12:0] EXP_MUL    = 13'd84;
	localparam logic [31:0] NEWTON_MUL = 32'd341;

	typedef struct packed {
		logic [RadicandW-1:0] a;
		logic [DenW-1:0]      rem;
		logic [QuoW-1:0]      quo;
		logic [DenW-1:0]      den;
		logic [EstW-1:0]      x;
		logic                 zq;
		logic                 low_range;
		logic [SmallW-1:0]    root_small;
	} crtn_div_t;

endpackage

`default_nettype wire

### rtl/crtn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crtn_front
	import crtn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [RadicandW-1:0] radicand,
	output logic                      out_valid,
	output crtn_div_t                 out
);

	logic [RadicandW-1:0] a_s1, a_s2, a_s3, a_s4;
	logic [6:0]           b_s1;
	logic                 small_s1, small_s2, small_s3, small_s4;
	logic [SmallW-1:0]    rsm_s1, rsm_s2, rsm_s3, rsm_s4;
	logic [5:0]           idx_s2;
	logic [4:0]           e_s2;
	logic [EstW-1:0]      x_s3, x_s4;
	logic [DenW-1:0]      den_s4;
	logic                 zq_s4;
	logic                 v_s1, v_s2, v_s3, v_s4;

	logic [6:0]           b_c;
	logic [8:0]           rsm_sum_c;
	logic [12:0]          eprod_c;
	logic [4:0]           e_c;
	logic [6:0]           sh_c;
	logic [RadicandW-1:0] shifted_c;
	logic [8:0]           seed_c;
	logic [28:0]          est_c;
	logic [EstW-1:0]      xm1_c;

	always_comb begin
		b_c = 7'd0;
		for (int i = 0; i < RadicandW; i++) begin
			if (radicand[i]) begin
				b_c = 7'(i + 1);
			end
		end
		rsm_sum_c = {1'b0, SEED_TABLE[radicand[5:0]]} + SMALL_ROUND;
	end

	always_comb begin
		eprod_c   = {6'd0, b_s1} * EXP_MUL;
		e_c       = eprod_c[12:8] - 5'd1;
		sh_c      = {2'd0, e_c} * 7'd3;
		shifted_c = a_s1 >> sh_c;
	end

	always_comb begin
		seed_c = {1'b0, SEED_TABLE[idx_s2]} + SEED_BIAS;
		est_c  = {20'd0, seed_c} << e_s2;
	end

	assign xm1_c = x_s3 - EstW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= radicand;
			b_s1     <= b_c;
			small_s1 <= (radicand[RadicandW-1:6] == '0);
			rsm_s1   <= rsm_sum_c[8:6];

			a_s2     <= a_s1;
			small_s2 <= small_s1;
			rsm_s2   <= rsm_s1;
			e_s2     <= e_c;
			idx_s2   <= shifted_c[5:0];

			a_s3     <= a_s2;
			small_s3 <= small_s2;
			rsm_s3   <= rsm_s2;
			x_s3     <= est_c[28:6];

			a_s4     <= a_s3;
			small_s4 <= small_s3;
			rsm_s4   <= rsm_s3;
			x_s4     <= x_s3;
			den_s4   <= {{(DenW-EstW){1'b0}}, x_s3} * {{(DenW-EstW){1'b0}}, xm1_c};
			zq_s4    <= (x_s3 <= EstW'(1));
		end
	end

	always_comb begin
		out_valid      = v_s4;
		out.a          = a_s4;
		out.rem        = '0;
		out.quo        = '0;
		out.den        = den_s4;
		out.x          = x_s4;
		out.zq         = zq_s4;
		out.low_range  = small_s4;
		out.root_small = rsm_s4;
	end

endmodule

`default_nettype wire

### rtl/crtn_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

module crtn_div_step
	import crtn_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  crtn_div_t      in,
	output logic           out_valid,
	output crtn_div_t      out
);

	logic [DenW:0] trial_c;
	logic [DenW:0] diff_c;
	logic          fits_c;
	crtn_div_t     next_c;
	logic          v_s1;
	crtn_div_t     d_s1;

	always_comb begin
		trial_c = {in.rem, in.a[RadicandW-1]};
		diff_c  = trial_c - {1'b0, in.den};
		fits_c  = (trial_c >= {1'b0, in.den});
		next_c  = in;
		next_c.a   = {in.a[RadicandW-2:0], 1'b0};
		next_c.rem = fits_c ? diff_c[DenW-1:0] : trial_c[DenW-1:0];
		next_c.quo = {in.quo[QuoW-2:0], fits_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= next_c;
		end
	end

	assign out_valid = v_s1;
	assign out       = d_s1;

endmodule

`default_nettype wire

### rtl/crtn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module crtn_back
	import crtn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_valid,
	input  crtn_div_t     in,
	output logic          out_valid,
	output logic [RootW-1:0] root
);

	logic [QuoW-1:0]   q_c;
	logic [31:0]       prod_c;
	logic [31:0]       sum_s1;
	logic              small_s1;
	logic [SmallW-1:0] rsm_s1;
	logic [RootW-1:0]  root_s2;
	logic              v_s1, v_s2;

	assign q_c    = in.zq ? '0 : in.quo;
	assign prod_c = sum_s1 * NEWTON_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1   <= {{(32-EstW-1){1'b0}}, in.x, 1'b0} + q_c;
			small_s1 <= in.low_range;
			rsm_s1   <= in.root_small;
			root_s2  <= small_s1 ? {{(RootW-SmallW){1'b0}}, rsm_s1} : prod_c[31:10];
		end
	end

	assign out_valid = v_s2;
	assign root      = root_s2;

endmodule

`default_nettype wire

### rtl/cube_root_table_newton.sv
// A result passes the front stages, the 64-stage restoring divider (one quotient
// bit per stage, setting the pipeline depth), the back stages and the output
// register to m_axis_tvalid. Throughput: one transaction per cycle while s_axis_tready is high.
// A two-entry output buffer holds results while m_axis_tready is low.
// Reset (arst_n low, asynchronous) clears all valid bits; the pipeline empties.
`timescale 1ns / 1ps
`default_nettype none

module cube_root_table_newton
	import crtn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] radicand
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // [21:0] root, [23:22] zero
);

	localparam int Steps = RadicandW;

	logic             en;
	logic             div_v [Steps+1];
	crtn_div_t        div_d [Steps+1];
	logic             p_valid;
	logic [RootW-1:0] p_root;
	logic             out_valid_q, skid_valid_q;
	logic [RootW-1:0] out_root_q, skid_root_q;
	logic             push, take;

	assign en = !skid_valid_q;

	crtn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.radicand  (s_axis_tdata),
		.out_valid (div_v[0]),
		.out       (div_d[0])
	);

	for (genvar g = 0; g < Steps; g++) begin : g_div
		crtn_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_v[g]),
			.in        (div_d[g]),
			.out_valid (div_v[g+1]),
			.out       (div_d[g+1])
		);
	end

	crtn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_v[Steps]),
		.in        (div_d[Steps]),
		.out_valid (p_valid),
		.root      (p_root)
	);

	assign push = en && p_valid;
	assign take = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_root_q <= skid_root_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_root_q <= p_root;
			end else begin
				skid_root_q <= p_root;
			end
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_root_q};

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready && p_valid))
		else $error("skid filled without a stalled output");

	a_push_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !m_axis_tready) |=> skid_valid_q)
		else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire
